// File: hdl/scts_pkg.sv
// Package for the sorted counted tag set: widths, command and status codes,
// and the structs passed between the top level and the cell chain. No dependencies.
`timescale 1ns / 1ps

package scts_pkg;

  localparam int CAPACITY = 32;
  localparam int TAG_W    = 16;
  localparam int CNT_W    = 16;
  localparam int OCC_W    = $clog2(CAPACITY + 1);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_QUERY  = 2'd0,
    CMD_GRANT  = 2'd1,
    CMD_REVOKE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REJECT  = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ADD,
    OP_SUB,
    OP_INSERT,
    OP_REMOVE
  } op_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    op_t              op;
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] stacks;
  } cell_ctl_t;

  // per-cell compare and arithmetic results
  typedef struct packed {
    logic             lt;
    logic             eq;
    logic             gt;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] sat;
    logic [CNT_W-1:0] dif;
  } cell_stat_t;

endpackage

// File: hdl/scts_if.sv
// Valid/ready channel interfaces for the command and response words.
// Depends on scts_pkg for field widths.
`timescale 1ns / 1ps

interface scts_cmd_if import scts_pkg::*;;
  logic             valid;
  logic             ready;
  logic [1:0]       cmd;
  logic [TAG_W-1:0] tag;
  logic [CNT_W-1:0] stacks;

  modport source (output valid, cmd, tag, stacks, input ready);
  modport sink   (input valid, cmd, tag, stacks, output ready);
endinterface

interface scts_rsp_if import scts_pkg::*;;
  logic             valid;
  logic             ready;
  logic             changed;
  logic             present;
  logic [CNT_W-1:0] stack_count;
  logic [1:0]       status;

  modport source (output valid, changed, present, stack_count, status, input ready);
  modport sink   (input valid, changed, present, stack_count, status, output ready);
endinterface

// File: hdl/scts_cell.sv
// One slot of the sorted tag chain: holds a tag and its count, compares
// against the broadcast tag and shifts with its neighbors. Depends on scts_pkg.
`timescale 1ns / 1ps

module scts_cell import scts_pkg::*; (
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  logic       valid,
  input  logic       left_lt,
  input  entry_t     left_ent,
  input  entry_t     right_ent,
  output entry_t     ent,
  output cell_stat_t stat
);

  entry_t         ent_r;
  entry_t         ent_nxt;
  logic [CNT_W:0] sum;

  assign ent = ent_r;
  assign sum = {1'b0, ent_r.cnt} + {1'b0, ctl.stacks};

  always_comb begin
    stat.lt  = valid && (ent_r.tag < ctl.tag);
    stat.eq  = valid && (ent_r.tag == ctl.tag);
    stat.gt  = ent_r.cnt > ctl.stacks;
    stat.cnt = ent_r.cnt;
    stat.sat = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
    stat.dif = ent_r.cnt - ctl.stacks;
  end

  always_comb begin
    ent_nxt = ent_r;
    case (ctl.op)
      OP_ADD: if (stat.eq) ent_nxt.cnt = stat.sat;
      OP_SUB: if (stat.eq) ent_nxt.cnt = stat.dif;
      OP_INSERT: begin
        // first slot not below the new tag takes it, later slots move up
        if (!stat.lt) begin
          if (left_lt) begin
            ent_nxt.tag = ctl.tag;
            ent_nxt.cnt = ctl.stacks;
          end else begin
            ent_nxt = left_ent;
          end
        end
      end
      OP_REMOVE: if (!stat.lt) ent_nxt = right_ent;
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// File: hdl/sorted_counted_tag_set.sv
// Top level of the sorted counted tag set: the cell chain, occupancy count,
// command decode and the registered response. Depends on scts_pkg, scts_if, scts_cell.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    cmd, tag, stacks
//   out_ch   out  valid/ready    changed, present, stack_count, status
//
// One command per cycle while no response is stalled; its response is registered and appears the next cycle.
// Search, count update, insert and remove all finish in the single broadcast
// compare across the cell chain, with the hit cell's data OR-collected.
// Reset (synchronous, rst_n low) empties the store and drops out_ch.valid.
// A stalled response holds in_ch.ready low until it is taken.
`timescale 1ns / 1ps

module sorted_counted_tag_set import scts_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  scts_cmd_if.sink   in_ch,
  scts_rsp_if.source out_ch
);

  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic             out_valid_r;
  logic             changed_r, present_r;
  logic [CNT_W-1:0] count_r;
  status_t          status_r;

  cell_ctl_t        ctl;
  cell_stat_t       stat  [CAPACITY];
  entry_t           ents  [CAPACITY];
  logic [CAPACITY-1:0] eq_vec;

  logic             acc;
  logic             hit, full, hit_gt;
  logic [CNT_W-1:0] hit_cnt, hit_sat, hit_dif;
  cmd_t             cmd;

  logic             res_changed, res_present;
  logic [CNT_W-1:0] res_count;
  status_t          res_status;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign cmd         = cmd_t'(in_ch.cmd);
  assign full        = occ_r == OCC_W'(CAPACITY);

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic   left_lt;
      entry_t left_ent, right_ent;
      if (gi == 0) begin : g_first
        assign left_lt  = 1'b1;
        assign left_ent = ents[0];
      end else begin : g_mid
        assign left_lt  = stat[gi-1].lt;
        assign left_ent = ents[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_ent = ents[gi];
      end else begin : g_inner
        assign right_ent = ents[gi+1];
      end
      scts_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .valid     (OCC_W'(gi) < occ_r),
        .left_lt   (left_lt),
        .left_ent  (left_ent),
        .right_ent (right_ent),
        .ent       (ents[gi]),
        .stat      (stat[gi])
      );
      assign eq_vec[gi] = stat[gi].eq;
    end
  endgenerate

  // at most one cell matches; collect its values
  always_comb begin
    hit_cnt = '0;
    hit_sat = '0;
    hit_dif = '0;
    hit_gt  = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_cnt = hit_cnt | ({CNT_W{eq_vec[i]}} & stat[i].cnt);
      hit_sat = hit_sat | ({CNT_W{eq_vec[i]}} & stat[i].sat);
      hit_dif = hit_dif | ({CNT_W{eq_vec[i]}} & stat[i].dif);
      hit_gt  = hit_gt | (eq_vec[i] & stat[i].gt);
    end
  end
  assign hit = |eq_vec;

  always_comb begin
    ctl.tag     = in_ch.tag;
    ctl.stacks  = in_ch.stacks;
    ctl.op      = OP_NONE;
    res_changed = 1'b0;
    res_present = hit;
    res_count   = hit ? hit_cnt : '0;
    res_status  = ST_OK;
    occ_nxt     = occ_r;
    case (cmd)
      CMD_GRANT: begin
        if (in_ch.stacks == '0 || in_ch.tag == '0) begin
          res_status = ST_REJECT;
        end else if (hit) begin
          ctl.op    = OP_ADD;
          res_count = hit_sat;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          ctl.op      = OP_INSERT;
          res_changed = 1'b1;
          res_present = 1'b1;
          res_count   = in_ch.stacks;
          occ_nxt     = occ_r + 1'b1;
        end
      end
      CMD_REVOKE: begin
        if (in_ch.stacks == '0) begin
          res_status = ST_REJECT;
        end else if (!hit) begin
          res_status = ST_MISSING;
        end else if (hit_gt) begin
          ctl.op    = OP_SUB;
          res_count = hit_dif;
        end else begin
          ctl.op      = OP_REMOVE;
          res_changed = 1'b1;
          res_present = 1'b0;
          res_count   = '0;
          occ_nxt     = occ_r - 1'b1;
        end
      end
      default: res_status = hit ? ST_OK : ST_MISSING;
    endcase
    if (!acc) begin
      ctl.op  = OP_NONE;
      occ_nxt = occ_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      changed_r <= res_changed;
      present_r <= res_present;
      count_r   <= res_count;
      status_r  <= res_status;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.changed     = changed_r;
  assign out_ch.present     = present_r;
  assign out_ch.stack_count = count_r;
  assign out_ch.status      = status_r;

  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_eq_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(eq_vec))
    else $error("more than one cell matches the tag");

  a_insert_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && ctl.op == OP_INSERT) |=> occ_r == $past(occ_r) + 1'b1)
    else $error("insert did not grow occupancy");

  a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("command taken while response stalled");

  a_present_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !present_r) |-> count_r == '0)
    else $error("absent tag reports a nonzero count");

endmodule

// File: test/sorted_counted_tag_set_tb.sv
// Testbench for sorted_counted_tag_set: directed and phased random command words,
// random stalls on both channels, responses checked against an in-bench tag store.
// Depends on scts_pkg, scts_if and the RTL of the block.
`timescale 1ns / 1ps

module sorted_counted_tag_set_tb;
  import scts_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;  // unused code, behaves as a query
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic [1:0]       code;
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] stacks;
    int               gap;     // idle cycles before the word
    bit               drain;   // hold off until all responses are in
  } cmd_word_t;

  typedef struct packed {
    logic             changed;
    logic             present;
    logic [CNT_W-1:0] stack_count;
    status_t          status;
  } rsp_word_t;

  logic clk;
  logic rst_n;

  scts_cmd_if cmd_bus ();
  scts_rsp_if rsp_bus ();

  sorted_counted_tag_set uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_bus),
    .out_ch (rsp_bus)
  );

  cmd_word_t cmd_backlog[$];
  rsp_word_t rsp_due[$];

  logic [TAG_W-1:0] tag_mem[CAPACITY];
  logic [CNT_W-1:0] cnt_mem[CAPACITY];
  int fill_level;

  int mismatches;
  int cycles;
  int rsp_stall;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    cmd_bus.valid = 1'b0;
    cmd_bus.cmd = CMD_QUERY;
    cmd_bus.tag = '0;
    cmd_bus.stacks = '0;
    rsp_bus.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Applies one command to the shadow store and returns the response it owes.
  function automatic rsp_word_t tag_set_apply(cmd_word_t w);
    int k;
    int j;
    bit hit;
    logic [CNT_W:0] sum;
    rsp_word_t r;
    k = 0;
    while (k < fill_level && tag_mem[k] < w.tag) k++;
    hit = (k < fill_level) && (tag_mem[k] == w.tag);
    r.changed = 1'b0;
    r.status = ST_OK;
    if (w.code == CMD_GRANT) begin
      if (w.stacks == 0 || w.tag == 0) begin
        r.status = ST_REJECT;
      end else if (hit) begin
        sum = cnt_mem[k] + w.stacks;
        cnt_mem[k] = (sum > CNT_MAX) ? CNT_MAX : sum[CNT_W-1:0];
      end else if (fill_level >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        for (j = fill_level; j > k; j--) begin
          tag_mem[j] = tag_mem[j-1];
          cnt_mem[j] = cnt_mem[j-1];
        end
        tag_mem[k] = w.tag;
        cnt_mem[k] = w.stacks;
        fill_level++;
        hit = 1'b1;
        r.changed = 1'b1;
      end
    end else if (w.code == CMD_REVOKE) begin
      if (w.stacks == 0) begin
        r.status = ST_REJECT;
      end else if (!hit) begin
        r.status = ST_MISSING;
      end else if (cnt_mem[k] > w.stacks) begin
        cnt_mem[k] = cnt_mem[k] - w.stacks;
      end else begin
        for (j = k; j + 1 < fill_level; j++) begin
          tag_mem[j] = tag_mem[j+1];
          cnt_mem[j] = cnt_mem[j+1];
        end
        fill_level--;
        hit = 1'b0;
        r.changed = 1'b1;
      end
    end else begin
      r.status = hit ? ST_OK : ST_MISSING;
    end
    r.present = hit;
    r.stack_count = hit ? cnt_mem[k] : '0;
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic cmd_word_t make_word(logic [1:0] code, int tag, int stacks);
    cmd_word_t w;
    w.code = code;
    w.tag = tag[TAG_W-1:0];
    w.stacks = stacks[CNT_W-1:0];
    w.gap = pick_gap();
    w.drain = 1'b0;
    return w;
  endfunction

  function automatic cmd_word_t random_word(int base, int span, int grant_pct,
                                            int revoke_pct);
    int r;
    int tag;
    int stacks;
    logic [1:0] code;
    r = $urandom_range(0, 99);
    if (r < grant_pct) code = CMD_GRANT;
    else if (r < grant_pct + revoke_pct) code = CMD_REVOKE;
    else if (r < 96) code = CMD_QUERY;
    else code = CMD_SPARE;
    r = $urandom_range(0, 99);
    if (r < 3) tag = 0;
    else if (r < 8) tag = $urandom_range(0, 65535);
    else tag = base + $urandom_range(0, span - 1);
    r = $urandom_range(0, 99);
    if (r < 5) stacks = 0;
    else if (r < 50) stacks = $urandom_range(1, 8);
    else if (r < 80) stacks = $urandom_range(1, 300);
    else if (r < 92) stacks = $urandom_range(0, 65535);
    else stacks = 16'hFFFF;
    return make_word(code, tag, stacks);
  endfunction

  function automatic cmd_word_t drain_mark();
    cmd_word_t w;
    w = make_word(CMD_QUERY, 0, 0);
    w.drain = 1'b1;
    return w;
  endfunction

  // command driver
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_bus.valid <= 1'b0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        rsp_due.push_back(tag_set_apply('{code: cmd_bus.cmd, tag: cmd_bus.tag,
                                          stacks: cmd_bus.stacks, gap: 0, drain: 1'b0}));
      end
      if (cmd_bus.valid && !cmd_bus.ready) begin
        // hold the word until it is taken
      end else if (cmd_backlog.size() == 0) begin
        cmd_bus.valid <= 1'b0;
      end else if (cmd_backlog[0].drain) begin
        cmd_bus.valid <= 1'b0;
        if (rsp_due.size() == 0) void'(cmd_backlog.pop_front());
      end else if (cmd_backlog[0].gap > 0) begin
        cmd_bus.valid <= 1'b0;
        cmd_backlog[0].gap--;
      end else begin
        cmd_bus.valid <= 1'b1;
        cmd_bus.cmd <= cmd_backlog[0].code;
        cmd_bus.tag <= cmd_backlog[0].tag;
        cmd_bus.stacks <= cmd_backlog[0].stacks;
        void'(cmd_backlog.pop_front());
      end
    end
  end

  // response monitor and sink-side stalls
  always @(posedge clk) begin
    rsp_word_t got;
    rsp_word_t want;
    bit calm;
    int r;
    if (!rst_n) begin
      rsp_bus.ready <= 1'b0;
      rsp_stall = 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        got.changed = rsp_bus.changed;
        got.present = rsp_bus.present;
        got.stack_count = rsp_bus.stack_count;
        got.status = status_t'(rsp_bus.status);
        if (rsp_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected response word: changed=%0b present=%0b count=%h status=%0d",
                     got.changed, got.present, got.stack_count, got.status);
        end else begin
          want = rsp_due.pop_front();
          if (got.changed !== want.changed || got.present !== want.present ||
              got.stack_count !== want.stack_count || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected changed=%0b present=%0b count=%h status=%0d, %s",
                       want.changed, want.present, want.stack_count, want.status,
                       $sformatf("got changed=%0b present=%0b count=%h status=%0d",
                                 got.changed, got.present, got.stack_count, got.status));
          end
        end
      end
      // in every third stretch of the run the sink starts no new stall
      calm = ((cycles / 150) % 3) == 0;
      if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
        r = $urandom_range(0, 99);
        if (!calm && r < 25) rsp_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int p;
    int i;
    int span;
    int base;
    int grant_pct;
    int revoke_pct;
    cmd_word_t w;
    mismatches = 0;
    cycles = 0;
    fill_level = 0;

    // directed: empty store, rejects, extremes, saturation, ordering, removal
    cmd_backlog.push_back(make_word(CMD_QUERY, 0, 0));
    cmd_backlog.push_back(make_word(CMD_REVOKE, 5, 1));
    cmd_backlog.push_back(make_word(CMD_GRANT, 0, 5));
    cmd_backlog.push_back(make_word(CMD_GRANT, 100, 0));
    cmd_backlog.push_back(make_word(CMD_GRANT, 16'hFFFF, 16'hFFFF));
    cmd_backlog.push_back(make_word(CMD_GRANT, 16'hFFFF, 1));
    cmd_backlog.push_back(make_word(CMD_GRANT, 1, 1));
    cmd_backlog.push_back(make_word(CMD_GRANT, 16'h8000, 16'h1234));
    cmd_backlog.push_back(make_word(CMD_SPARE, 16'h8000, 16'hFFFF));
    cmd_backlog.push_back(make_word(CMD_QUERY, 16'h8000, 0));
    cmd_backlog.push_back(make_word(CMD_REVOKE, 16'h8000, 0));
    cmd_backlog.push_back(make_word(CMD_REVOKE, 16'h8000, 16'h0034));
    cmd_backlog.push_back(make_word(CMD_REVOKE, 16'h8000, 16'h1200));
    cmd_backlog.push_back(make_word(CMD_REVOKE, 1, 16'hFFFF));
    cmd_backlog.push_back(make_word(CMD_REVOKE, 0, 1));
    cmd_backlog.push_back(make_word(CMD_GRANT, 0, 0));
    cmd_backlog.push_back(make_word(CMD_QUERY, 16'h8000, 0));
    cmd_backlog.push_back(make_word(CMD_GRANT, 16'hFFFF, 0));
    cmd_backlog.push_back(make_word(CMD_REVOKE, 16'hFFFF, 16'hFFFF));
    cmd_backlog.push_back(make_word(CMD_QUERY, 16'hFFFF, 16'h5555));
    cmd_backlog.push_back(drain_mark());

    // random phases over tag windows of varied width; narrow ones give hits,
    // windows near 40-48 wide fill the store, revoke-heavy phases empty it
    for (p = 0; p < 11; p++) begin
      case (p % 5)
        0: span = 8;
        1: span = 48;
        2: span = 400;
        3: span = 40;
        default: span = 65536;
      endcase
      base = (span == 65536) ? 0 : $urandom_range(0, 65536 - span);
      if (p == 5) base = 0;
      grant_pct = (p % 3 == 2) ? 20 : 55;
      revoke_pct = (p % 3 == 2) ? 60 : 25;
      if (p % 5 == 3) begin
        grant_pct = 75;
        revoke_pct = 10;
      end
      for (i = 0; i < 100; i++) begin
        w = random_word(base, span, grant_pct, revoke_pct);
        if (i < 25) w.gap = 0;
        cmd_backlog.push_back(w);
      end
      if (p == 4 || p == 8) cmd_backlog.push_back(drain_mark());
    end

    wait (rst_n === 1'b1);
    while (cmd_backlog.size() > 0 || cmd_bus.valid || rsp_due.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && rsp_due.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
hdl/scts_pkg.sv
hdl/scts_if.sv
hdl/scts_cell.sv
hdl/sorted_counted_tag_set.sv
test/sorted_counted_tag_set_tb.sv
